// File: sv/rap_pkg.sv
// ----------------------------------------------------------------------------
// rap_pkg
// Shared types and constants for the rectangle atlas packer.
// ----------------------------------------------------------------------------
package rap_pkg;

   localparam int MAX_FREE_DEF = 64;
   localparam int MAX_SIDE_DEF = 4096;

   localparam int SIDE_W  = 13;
   localparam int ID_W    = 16;
   localparam int AREA_W  = 25;
   localparam int CSR_IDX_W = 1;

   localparam logic [SIDE_W-1:0] ATLAS_RESET = 13'd1024;

   localparam logic [CSR_IDX_W-1:0] CSR_ATLAS_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ATLAS_HEIGHT = 1'd1;

   localparam logic [1:0] ST_PLACED = 2'd0;
   localparam logic [1:0] ST_NO_FIT = 2'd1;
   localparam logic [1:0] ST_FULL   = 2'd2;

   typedef struct packed {
      logic [SIDE_W-1:0] x;
      logic [SIDE_W-1:0] y;
      logic [SIDE_W-1:0] w;
      logic [SIDE_W-1:0] h;
   } rect_type;

   typedef struct packed {
      logic [ID_W-1:0]   image_id;
      logic [SIDE_W-1:0] req_width;
      logic [SIDE_W-1:0] req_height;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [SIDE_W-1:0] pos_x;
      logic [SIDE_W-1:0] pos_y;
      logic [ID_W-1:0]   echo_id;
      logic [AREA_W-1:0] used_area;
   } rsp_type;

   typedef struct packed {
      logic              restart;
      rect_type          init;
      logic              check;
      logic [SIDE_W-1:0] chk_w;
      logic [SIDE_W-1:0] chk_h;
      logic              apply;
      logic [1:0]        np;
      rect_type          piece0;
      rect_type          piece1;
   } cell_cmd_type;

   typedef struct packed {
      logic hit;
      logic prev_hit;
      logic after_hit;
   } cell_sel_type;

endpackage

// File: sv/rect_atlas_packer.sv
// ----------------------------------------------------------------------------
// rect_atlas_packer
// Guillotine first-fit rectangle packer over a row of free-list cells.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive req_data and raise start; the word is taken at a
//   clock edge where start is high and busy is low.
//   Result channel: rsp_valid is high for one cycle with rsp_data; the
//   receiver must take it then, it cannot stall the block.
//   Steps per request: fit check in every cell, first-fit pick and split,
//   then one shift/insert step across the cell row; busy stays high until
//   the result is registered, so a new request waits for the last one.
//   Config: csr_we with csr_index and csr_wdata writes atlas width or height
//   (write only while idle); any such write restarts the free list as the
//   whole atlas and clears the used area.
//   Reset: synchronous, active high; atlas 1024 x 1024, one free entry, used
//   area zero, no clearing pass.
// ----------------------------------------------------------------------------
module rect_atlas_packer #(
   parameter int MAX_FREE = rap_pkg::MAX_FREE_DEF,
   parameter int MAX_SIDE = rap_pkg::MAX_SIDE_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  rap_pkg::req_type              req_data,
   output logic                          rsp_valid,
   output rap_pkg::rsp_type              rsp_data,
   input  logic                          csr_we,
   input  logic [rap_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rap_pkg::SIDE_W-1:0]    csr_wdata
);

   localparam int CNT_W = $clog2(MAX_FREE + 1);
   localparam int SW    = rap_pkg::SIDE_W;

   typedef enum logic [1:0] {S_IDLE, S_PICK, S_APPLY} state_type;

   state_type                     state_ff;
   logic [CNT_W-1:0]              count_ff;
   logic [rap_pkg::AREA_W-1:0]    area_ff;
   logic [SW-1:0]                 aw_ff, ah_ff, aw_in, ah_in;
   rap_pkg::req_type              req_ff;
   logic [MAX_FREE-1:0]           oh_ff, oh_in;
   logic [1:0]                    np_ff, np_in;
   rap_pkg::rect_type             p0_ff, p0_in, p1_ff, p1_in;
   logic [1:0]                    st_ff, st_in;
   logic [SW-1:0]                 px_ff, py_ff;
   logic [2*SW-1:0]               prod_ff;
   logic                          rsp_valid_ff;
   rap_pkg::rsp_type              rsp_ff;

   rap_pkg::cell_cmd_type         cmd;
   rap_pkg::rect_type             rects [MAX_FREE];
   logic [MAX_FREE-1:0]           fits;
   logic [MAX_FREE-1:0]           after_mask;
   logic                          restart, accept;
   rap_pkg::rect_type             e, c0, c1;
   logic [SW-1:0]                 dw, dh;
   logic                          c0_ok, c1_ok;
   logic [rap_pkg::AREA_W-1:0]    area_sum;

   function automatic logic [SW-1:0] clamp_side(input logic [SW-1:0] v);
      logic [SW-1:0] r;
      r = v;
      if (32'(v) > 32'(MAX_SIDE)) begin
         r = SW'(MAX_SIDE);
      end
      return r;
   endfunction

   assign accept  = start && (state_ff == S_IDLE);
   assign restart = csr_we &&
                    (csr_index == rap_pkg::CSR_ATLAS_WIDTH ||
                     csr_index == rap_pkg::CSR_ATLAS_HEIGHT);

   always_comb begin
      aw_in = aw_ff;
      ah_in = ah_ff;
      if (csr_we) begin
         unique case (csr_index)
            rap_pkg::CSR_ATLAS_WIDTH:  aw_in = clamp_side(csr_wdata);
            rap_pkg::CSR_ATLAS_HEIGHT: ah_in = clamp_side(csr_wdata);
            default: ;
         endcase
      end
   end

   always_comb begin
      cmd         = '0;
      cmd.restart = restart;
      cmd.init    = '{x: '0, y: '0, w: aw_in, h: ah_in};
      cmd.check   = accept;
      cmd.chk_w   = req_data.req_width;
      cmd.chk_h   = req_data.req_height;
      cmd.apply   = (state_ff == S_APPLY) && (st_ff == rap_pkg::ST_PLACED);
      cmd.np      = np_ff;
      cmd.piece0  = p0_ff;
      cmd.piece1  = p1_ff;
   end

   assign after_mask = ~(oh_ff - MAX_FREE'(1)) & ~oh_ff;

   for (genvar i = 0; i < MAX_FREE; i++) begin : g_cell
      rap_pkg::cell_sel_type sel;
      rap_pkg::rect_type     prv, nxt;
      assign sel.hit       = oh_ff[i];
      assign sel.prev_hit  = (i > 0) ? oh_ff[(i > 0) ? i-1 : 0] : 1'b0;
      assign sel.after_hit = after_mask[i];
      assign prv = (i > 0) ? rects[(i > 0) ? i-1 : 0] : '0;
      assign nxt = (i < MAX_FREE-1) ? rects[(i < MAX_FREE-1) ? i+1 : i] : '0;
      rap_cell #(.CELL_IDX(i), .CNT_W(CNT_W)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .sel       (sel),
         .count     (count_ff),
         .prev_rect (prv),
         .next_rect (nxt),
         .rect      (rects[i]),
         .fit       (fits[i])
      );
   end

   always_comb begin
      oh_in = fits & (~fits + MAX_FREE'(1));
      e     = '0;
      for (int i = 0; i < MAX_FREE; i++) begin
         e = e | (rects[i] & {$bits(rap_pkg::rect_type){oh_in[i]}});
      end
      dw = e.w - req_ff.req_width;
      dh = e.h - req_ff.req_height;
      if (dh <= dw) begin
         c0 = '{x: e.x, y: e.y + req_ff.req_height, w: req_ff.req_width, h: dh};
         c1 = '{x: e.x + req_ff.req_width, y: e.y, w: dw, h: e.h};
      end else begin
         c0 = '{x: e.x + req_ff.req_width, y: e.y, w: dw, h: req_ff.req_height};
         c1 = '{x: e.x, y: e.y + req_ff.req_height, w: e.w, h: dh};
      end
      c0_ok = (c0.w != '0) && (c0.h != '0);
      c1_ok = (c1.w != '0) && (c1.h != '0);
      np_in = 2'(c0_ok) + 2'(c1_ok);
      p0_in = c0_ok ? c0 : c1;
      p1_in = c1;
      priority if (fits == '0) begin
         st_in = rap_pkg::ST_NO_FIT;
      end else if (np_in == 2'd2 && 32'(count_ff) == MAX_FREE) begin
         st_in = rap_pkg::ST_FULL;
      end else begin
         st_in = rap_pkg::ST_PLACED;
      end
   end

   assign area_sum = (st_ff == rap_pkg::ST_PLACED) ?
                     area_ff + prod_ff[rap_pkg::AREA_W-1:0] : area_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= CNT_W'(1);
         area_ff      <= '0;
         aw_ff        <= rap_pkg::ATLAS_RESET;
         ah_ff        <= rap_pkg::ATLAS_RESET;
         oh_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         aw_ff        <= aw_in;
         ah_ff        <= ah_in;
         rsp_valid_ff <= 1'b0;
         if (restart) begin
            count_ff <= CNT_W'((aw_in != '0) && (ah_in != '0));
            area_ff  <= '0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  req_ff   <= req_data;
                  state_ff <= S_PICK;
               end
            end
            S_PICK: begin
               oh_ff    <= oh_in;
               np_ff    <= np_in;
               p0_ff    <= p0_in;
               p1_ff    <= p1_in;
               st_ff    <= st_in;
               px_ff    <= (st_in == rap_pkg::ST_PLACED) ? e.x : '0;
               py_ff    <= (st_in == rap_pkg::ST_PLACED) ? e.y : '0;
               prod_ff  <= req_ff.req_width * req_ff.req_height;
               state_ff <= S_APPLY;
            end
            S_APPLY: begin
               rsp_valid_ff      <= 1'b1;
               rsp_ff.status     <= st_ff;
               rsp_ff.pos_x      <= px_ff;
               rsp_ff.pos_y      <= py_ff;
               rsp_ff.echo_id    <= req_ff.image_id;
               rsp_ff.used_area  <= area_sum;
               if (st_ff == rap_pkg::ST_PLACED) begin
                  count_ff <= count_ff + CNT_W'(np_ff) - CNT_W'(1);
                  area_ff  <= area_sum;
               end
               oh_ff    <= '0;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy) else $error("accepted word did not raise busy");
   a_rsp_timing: assert property (@(posedge clock) disable iff (reset)
      accept |=> ##2 rsp_valid) else $error("result not three cycles after accept");
   a_hit_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(oh_ff)) else $error("more than one hit cell");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= MAX_FREE) else $error("free count overflow");
`endif

endmodule

// File: sv/rap_cell.sv
// ----------------------------------------------------------------------------
// rap_cell
// One free-list entry: fit check and shift/insert against its neighbors.
// ----------------------------------------------------------------------------
module rap_cell #(
   parameter int CELL_IDX = 0,
   parameter int CNT_W    = 7
) (
   input  logic                  clock,
   input  logic                  reset,
   input  rap_pkg::cell_cmd_type cmd,
   input  rap_pkg::cell_sel_type sel,
   input  logic [CNT_W-1:0]      count,
   input  rap_pkg::rect_type     prev_rect,
   input  rap_pkg::rect_type     next_rect,
   output rap_pkg::rect_type     rect,
   output logic                  fit
);

   rap_pkg::rect_type rect_ff, rect_in;
   logic              fit_ff, fit_in;
   logic              valid;

   assign valid = 32'(CELL_IDX) < 32'(count);

   always_comb begin
      rect_in = rect_ff;
      fit_in  = fit_ff;
      if (cmd.check) begin
         fit_in = valid && (cmd.chk_w <= rect_ff.w) && (cmd.chk_h <= rect_ff.h);
      end
      if (cmd.restart) begin
         rect_in = (CELL_IDX == 0) ? cmd.init : '0;
      end else if (cmd.apply) begin
         if (sel.hit) begin
            rect_in = (cmd.np != 2'd0) ? cmd.piece0 : next_rect;
         end else if (sel.after_hit) begin
            unique case (cmd.np)
               2'd0:    rect_in = next_rect;
               2'd1:    rect_in = rect_ff;
               default: rect_in = sel.prev_hit ? cmd.piece1 : prev_rect;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rect_ff <= (CELL_IDX == 0) ?
                    rap_pkg::rect_type'{x: '0, y: '0, w: rap_pkg::ATLAS_RESET,
                                        h: rap_pkg::ATLAS_RESET} :
                    rap_pkg::rect_type'('0);
         fit_ff  <= 1'b0;
      end else begin
         rect_ff <= rect_in;
         fit_ff  <= fit_in;
      end
   end

   assign rect = rect_ff;
   assign fit  = fit_ff;

endmodule

// File: verif/tb_rect_atlas_packer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rect_atlas_packer
// Self-checking bench for the guillotine first-fit atlas packer: directed and
// random placement requests across several atlas sizes, each result compared
// against a free-list predictor kept in a small scoreboard class.
// ----------------------------------------------------------------------------
module tb_rect_atlas_packer;

   localparam int FREE_DEPTH = rap_pkg::MAX_FREE_DEF;
   localparam int SIDE_CAP   = rap_pkg::MAX_SIDE_DEF;
   localparam int STALL_MAX  = 1000;

   class rap_scoreboard;
      int unsigned fx[FREE_DEPTH], fy[FREE_DEPTH], fw[FREE_DEPTH], fh[FREE_DEPTH];
      int unsigned n_free, area, width_cfg, height_cfg;
      rap_pkg::rsp_type expected_q[$];
      int          errors;

      function void restart();
         n_free = 0;
         area   = 0;
         if (width_cfg != 0 && height_cfg != 0) begin
            fx[0] = 0; fy[0] = 0; fw[0] = width_cfg; fh[0] = height_cfg;
            n_free = 1;
         end
      endfunction

      function void write_reg(logic [rap_pkg::CSR_IDX_W-1:0] idx,
                              logic [rap_pkg::SIDE_W-1:0] val);
         int unsigned v;
         v = (32'(val) > SIDE_CAP) ? SIDE_CAP : 32'(val);
         if (idx == rap_pkg::CSR_ATLAS_WIDTH) width_cfg = v;
         else height_cfg = v;
         restart();
      endfunction

      function void note(rap_pkg::req_type rq);
         rap_pkg::rsp_type r;
         int unsigned w, h, hit, dw, dh, np, tail;
         int unsigned kx[2], ky[2], kw[2], kh[2], cx[2], cy[2], cw[2], ch[2];
         bit found;
         w = 32'(rq.req_width); h = 32'(rq.req_height); found = 0; hit = 0; np = 0;
         r = '0;
         r.status = rap_pkg::ST_NO_FIT;
         r.echo_id = rq.image_id;
         for (int i = 0; i < n_free; i++)
            if (!found && w <= fw[i] && h <= fh[i]) begin
               found = 1; hit = i;
            end
         if (found) begin
            dw = fw[hit] - w; dh = fh[hit] - h;
            if (dh <= dw) begin
               cx[0] = fx[hit];     cy[0] = fy[hit] + h; cw[0] = w;       ch[0] = dh;
               cx[1] = fx[hit] + w; cy[1] = fy[hit];     cw[1] = dw;      ch[1] = fh[hit];
            end else begin
               cx[0] = fx[hit] + w; cy[0] = fy[hit];     cw[0] = dw;      ch[0] = h;
               cx[1] = fx[hit];     cy[1] = fy[hit] + h; cw[1] = fw[hit]; ch[1] = dh;
            end
            for (int k = 0; k < 2; k++)
               if (cw[k] != 0 && ch[k] != 0) begin
                  kx[np] = cx[k]; ky[np] = cy[k]; kw[np] = cw[k]; kh[np] = ch[k];
                  np++;
               end
            if (n_free - 1 + np > FREE_DEPTH) begin
               r.status = rap_pkg::ST_FULL;
            end else begin
               r.status = rap_pkg::ST_PLACED;
               r.pos_x  = rap_pkg::SIDE_W'(fx[hit]);
               r.pos_y  = rap_pkg::SIDE_W'(fy[hit]);
               tail = n_free - hit - 1;
               if (np == 0)
                  for (int j = 0; j < tail; j++) begin
                     fx[hit+j] = fx[hit+1+j]; fy[hit+j] = fy[hit+1+j];
                     fw[hit+j] = fw[hit+1+j]; fh[hit+j] = fh[hit+1+j];
                  end
               else if (np == 2)
                  for (int j = tail; j > 0; j--) begin
                     fx[hit+1+j] = fx[hit+j]; fy[hit+1+j] = fy[hit+j];
                     fw[hit+1+j] = fw[hit+j]; fh[hit+1+j] = fh[hit+j];
                  end
               for (int k = 0; k < np; k++) begin
                  fx[hit+k] = kx[k]; fy[hit+k] = ky[k]; fw[hit+k] = kw[k]; fh[hit+k] = kh[k];
               end
               n_free = n_free - 1 + np;
               area   = (area + w * h) & 32'h1FF_FFFF;
            end
         end
         r.used_area = rap_pkg::AREA_W'(area);
         expected_q.push_back(r);
      endfunction

      function void check(rap_pkg::rsp_type got);
         rap_pkg::rsp_type e;
         if (expected_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result word %p", got);
            return;
         end
         e = expected_q.pop_front();
         if (got !== e) begin
            errors++;
            if (errors <= 10) $display("mismatch: expected %p, got %p", e, got);
         end
      endfunction
   endclass

   logic    clock = 0;
   logic    reset = 1;
   logic    start = 0;
   logic    busy;
   rap_pkg::req_type req_data = '0;
   logic    rsp_valid;
   rap_pkg::rsp_type rsp_data;
   logic    csr_we = 0;
   logic [rap_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [rap_pkg::SIDE_W-1:0]    csr_wdata = '0;

   rap_scoreboard placements = new();
   int  stall_cycles = 0;
   bit  calm = 0;

   rect_atlas_packer u_top (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid) placements.check(rsp_data);
      if ((start && !busy) || rsp_valid || reset) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_MAX) begin
         $display("[rect_atlas_packer] ERROR");
         $finish;
      end
   end

   task automatic idle_gap();
      if (!calm && $urandom_range(0, 3) == 0) begin
         start <= 0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
   endtask

   task automatic place(logic [rap_pkg::ID_W-1:0] id, logic [rap_pkg::SIDE_W-1:0] w,
                        logic [rap_pkg::SIDE_W-1:0] h);
      rap_pkg::req_type rq;
      rq.image_id = id; rq.req_width = w; rq.req_height = h;
      idle_gap();
      req_data <= rq;
      start    <= 1;
      do @(posedge clock); while (busy);
      placements.note(rq);
      @(negedge clock);
   endtask

   task automatic drain();
      start <= 0;
      while (placements.expected_q.size() != 0) @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   task automatic set_atlas(logic [rap_pkg::SIDE_W-1:0] w, logic [rap_pkg::SIDE_W-1:0] h);
      drain();
      csr_we <= 1; csr_index <= rap_pkg::CSR_ATLAS_WIDTH; csr_wdata <= w;
      @(negedge clock);
      csr_index <= rap_pkg::CSR_ATLAS_HEIGHT; csr_wdata <= h;
      @(negedge clock);
      csr_we <= 0;
      placements.write_reg(rap_pkg::CSR_ATLAS_WIDTH, w);
      placements.write_reg(rap_pkg::CSR_ATLAS_HEIGHT, h);
      @(negedge clock);
   endtask

   function automatic logic [rap_pkg::SIDE_W-1:0] pick_side();
      int unsigned p;
      p = $urandom_range(0, 99);
      if (p < 5)  return '0;
      if (p < 75) return rap_pkg::SIDE_W'($urandom_range(1, 63));
      if (p < 92) return rap_pkg::SIDE_W'($urandom_range(64, 1100));
      return rap_pkg::SIDE_W'($urandom_range(0, 8191));
   endfunction

   initial begin
      placements.width_cfg  = 32'(rap_pkg::ATLAS_RESET);
      placements.height_cfg = 32'(rap_pkg::ATLAS_RESET);
      placements.restart();
      repeat (6) @(negedge clock);
      reset <= 0;
      @(negedge clock);

      place(16'h0000, 0, 0);
      place(16'hFFFF, 1024, 1);
      place(16'h1234, 8191, 8191);
      place(16'h5555, 100, 1023);
      place(16'hAAAA, 924, 1023);
      place(16'h0001, 1, 1);
      set_atlas(1, 1);
      place(16'h0002, 1, 1);
      place(16'h0003, 1, 1);
      place(16'h0004, 0, 0);
      set_atlas(0, 8191);
      place(16'h0005, 0, 0);
      set_atlas(4096, 4096);
      place(16'h0006, 4096, 4095);
      place(16'h0007, 4096, 1);
      place(16'h0008, 1, 1);
      set_atlas(300, 200);
      place(16'h0009, 200, 20);
      place(16'h000A, 20, 150);
      place(16'h000B, 301, 1);

      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: set_atlas(4096, 4096);
            1: set_atlas(1024, 512);
            2: set_atlas(8191, 8191);
            3: set_atlas(rap_pkg::SIDE_W'($urandom_range(1, 8191)),
                         rap_pkg::SIDE_W'($urandom_range(1, 8191)));
            default: set_atlas(2048, 4096);
         endcase
         calm = (ph == 4);
         for (int i = 0; i < 160; i++) begin
            if (i == 80) drain();
            place(rap_pkg::ID_W'($urandom), pick_side(), pick_side());
         end
      end

      drain();
      if (placements.errors == 0) $display("[rect_atlas_packer] OK");
      else $display("[rect_atlas_packer] ERROR");
      $finish;
   end
endmodule
